>>> rtl/ssk_pkg.sv
// Shared types, constants and register codes for the spaced-seed k-mer extractor.
`timescale 1ns / 1ps

package ssk_pkg;

    localparam int WINDOW_DEF  = 32;   // default window depth in bases
    localparam int MAX_WINDOW  = 32;   // largest supported window
    localparam int KMER_W      = 64;
    localparam int SLOTS       = KMER_W / 2;
    localparam int RANK_W      = 5;
    localparam int SPAN_W      = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_MASK    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_SEED = 2'd2;

    localparam logic [31:0] BASE_MASK_RST   = 32'hFFFF_FFFF;
    localparam logic [5:0]  MASK_LENGTH_RST = 6'd16;
    localparam logic [15:0] LFSR_RST        = 16'h0001;
    localparam logic [15:0] LFSR_TAPS       = 16'hB400;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    typedef struct packed {
        logic [7:0] symbol;
        logic       first;
    } t_in_item;

    typedef struct packed {
        logic [KMER_W-1:0] packed_kmer;
        logic [5:0]        selected_count;
        logic              ready_res;
        logic              was_unknown;
    } t_out_item;

    // Per-window-position selection derived from the seed configuration.
    // Index k counts bases from the newest (k = 0).
    typedef struct packed {
        logic [MAX_WINDOW-1:0]             sel;
        logic [MAX_WINDOW-1:0][RANK_W-1:0] rank;
        logic [SPAN_W-1:0]                 count;
        logic [SPAN_W-1:0]                 span;
    } t_plan;

endpackage

>>> rtl/spaced_seed_kmer_extractor_core.sv
// Top level of the spaced-seed k-mer extractor.
`timescale 1ns / 1ps
//
//  Channel   Dir  Handshake                    Payload
//  --------  ---  ---------------------------  ---------------------------------
//  in        in   i_in_valid / o_in_ready      i_in_data  (symbol, first)
//  out       out  o_out_valid / i_out_ready    o_out_data (kmer, count, ready, unknown)
//  cfg       in   i_cfg_we (no wait)           i_cfg_idx, i_cfg_wdata
//
//  One transaction per cycle sustained while the output side accepts; a result
//  passes from its input transaction through stage 1 (window/state update)
//  and then the output register (selection and packing), where it can be taken.
//  The depth is set by the stage-1 register and the output register; the
//  selection plan is registered off the mask registers, behind the write to them.
//  Reset (synchronous, active low) clears window, fill count, pipeline valids
//  and restores mask registers and LFSR to their defaults.
//  Output stalls back up through stage 1; input stays ready while stage 1
//  can drain or is empty.

module spaced_seed_kmer_extractor_core #(
    parameter int P_WINDOW = ssk_pkg::WINDOW_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  ssk_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output ssk_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_we,
    input  logic [ssk_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ssk_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import ssk_pkg::*;

    localparam int WIN_W  = 2 * P_WINDOW;
    localparam int FILL_W = $clog2(P_WINDOW + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(P_WINDOW);

    // configuration
    logic [31:0] r_base_mask;
    logic [5:0]  r_mask_length;

    // sequence state
    logic [WIN_W-1:0]  r_window,  n_window;
    logic [FILL_W-1:0] r_fill,    n_fill;
    logic [15:0]       r_lfsr;

    // stage 1: snapshot of the updated state
    logic              r_s1_valid;
    logic [WIN_W-1:0]  r_s1_window;
    logic [FILL_W-1:0] r_s1_fill;
    logic              r_s1_unknown;

    // output register
    logic      r_out_valid;
    t_out_item r_out, n_out;

    logic [1:0]  code;
    logic        unknown;
    logic [15:0] lfsr_next;
    logic [15:0] seed;
    t_plan       plan;
    logic [KMER_W-1:0] kmer;
    logic        in_acc;
    logic        s1_move;

    ssk_decode u_decode (
        .i_symbol    (i_in_data.symbol),
        .i_lfsr      (r_lfsr),
        .o_code      (code),
        .o_unknown   (unknown),
        .o_lfsr_next (lfsr_next)
    );

    ssk_plan #(.P_WINDOW(P_WINDOW)) u_plan (
        .i_clk         (i_clk),
        .i_base_mask   (r_base_mask),
        .i_mask_length (r_mask_length),
        .o_plan        (plan)
    );

    ssk_pack #(.P_WINDOW(P_WINDOW)) u_pack (
        .i_window (r_s1_window),
        .i_plan   (plan),
        .o_kmer   (kmer)
    );

    // handshake: stage 1 drains into the output register when it is free
    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign in_acc     = i_in_valid && o_in_ready;

    // zero seed would lock the LFSR
    assign seed = (i_cfg_wdata[15:0] == 16'h0000) ? LFSR_RST : i_cfg_wdata[15:0];

    always_comb begin
        logic [FILL_W-1:0] base_fill;
        base_fill = i_in_data.first ? '0 : r_fill;
        n_window  = {r_window[WIN_W-3:0], code};
        n_fill    = (base_fill < FILL_MAX) ? base_fill + FILL_W'(1) : base_fill;
    end

    always_comb begin
        n_out.packed_kmer    = kmer;
        n_out.selected_count = plan.count;
        n_out.ready_res      = (SPAN_W'(r_s1_fill) >= plan.span);
        n_out.was_unknown    = r_s1_unknown;
    end

    // configuration registers and LFSR; a seed write reloads the LFSR,
    // otherwise it steps with each accepted unknown character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_mask   <= BASE_MASK_RST;
            r_mask_length <= MASK_LENGTH_RST;
            r_lfsr        <= LFSR_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE_MASK:   r_base_mask   <= i_cfg_wdata;
                    CFG_MASK_LENGTH: r_mask_length <= i_cfg_wdata[5:0];
                    default: ;
                endcase
            end
            if (i_cfg_we && (i_cfg_idx == CFG_UNKNOWN_SEED)) begin
                r_lfsr <= seed;
            end else if (in_acc) begin
                r_lfsr <= lfsr_next;
            end
        end
    end

    // window and fill count (saturating, restarted by first) update on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_fill   <= '0;
        end else if (in_acc) begin
            r_window <= n_window;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_window  <= n_window;
            r_s1_fill    <= n_fill;
            r_s1_unknown <= unknown;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // input is only held off while stage 1 is occupied
    a_ready_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_s1_valid)
        else $error("input stalled with empty stage 1");

    // an accepted transaction always occupies stage 1 next cycle
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted transaction lost before stage 1");

    // a result held under backpressure keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");

    // LFSR never locks at zero, fill count saturates at the window depth
    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lfsr != 16'h0000) && (r_fill <= FILL_MAX))
        else $error("LFSR or fill count out of range");
`endif

endmodule

>>> rtl/ssk_decode.sv
// Nucleotide decoder with LFSR substitution for unknown characters.
`timescale 1ns / 1ps

module ssk_decode (
    input  logic [7:0]  i_symbol,
    input  logic [15:0] i_lfsr,
    output logic [1:0]  o_code,
    output logic        o_unknown,
    output logic [15:0] o_lfsr_next
);
    import ssk_pkg::*;

    always_comb begin
        o_unknown   = 1'b0;
        o_lfsr_next = i_lfsr;
        case (i_symbol)
            "A", "a", "U", "u": o_code = CODE_A;
            "C", "c":           o_code = CODE_C;
            "G", "g":           o_code = CODE_G;
            "T", "t":           o_code = CODE_T;
            default: begin
                o_unknown   = 1'b1;
                o_code      = i_lfsr[1:0];
                o_lfsr_next = (i_lfsr >> 1) ^ (i_lfsr[0] ? LFSR_TAPS : 16'h0000);
            end
        endcase
    end

endmodule

>>> rtl/ssk_plan.sv
// Registered selection plan: which window bases the seed picks and their output slots.
`timescale 1ns / 1ps

module ssk_plan #(
    parameter int P_WINDOW = ssk_pkg::WINDOW_DEF
) (
    input  logic                       i_clk,
    input  logic [31:0]                i_base_mask,
    input  logic [5:0]                 i_mask_length,
    output ssk_pkg::t_plan             o_plan
);
    import ssk_pkg::*;

    localparam logic [SPAN_W-1:0] WIN_LEN = SPAN_W'(P_WINDOW);

    t_plan r_plan;
    t_plan n_plan;

    always_comb begin
        logic [SPAN_W-1:0]     span;
        logic [SPAN_W-1:0]     pos;
        logic [MAX_WINDOW-1:0] sel;
        logic [MAX_WINDOW-1:0] below;
        span = (i_mask_length > WIN_LEN) ? WIN_LEN : i_mask_length;
        sel  = '0;
        // base k (newest = 0) sits at seed position span-1-k
        for (int k = 0; k < P_WINDOW; k++) begin
            pos = span - SPAN_W'(k) - SPAN_W'(1);
            if (SPAN_W'(k) < span) begin
                sel[k] = i_base_mask[pos[RANK_W-1:0]];
            end
        end
        n_plan.sel  = sel;
        n_plan.span = span;
        n_plan.count = SPAN_W'($countones(sel));
        // slot of a selected base = number of selected newer bases
        for (int k = 0; k < MAX_WINDOW; k++) begin
            below          = (MAX_WINDOW'(1) << k) - MAX_WINDOW'(1);
            n_plan.rank[k] = RANK_W'($countones(sel & below));
        end
    end

    always_ff @(posedge i_clk) begin
        r_plan <= n_plan;
    end

    assign o_plan = r_plan;

endmodule

>>> rtl/ssk_pack.sv
// Compaction of the selected window bases into the packed k-mer.
`timescale 1ns / 1ps

module ssk_pack #(
    parameter int P_WINDOW = ssk_pkg::WINDOW_DEF
) (
    input  logic [2*P_WINDOW-1:0]      i_window,
    input  ssk_pkg::t_plan             i_plan,
    output logic [ssk_pkg::KMER_W-1:0] o_kmer
);
    import ssk_pkg::*;

    always_comb begin
        o_kmer = '0;
        for (int r = 0; r < SLOTS; r++) begin
            for (int k = 0; k < P_WINDOW; k++) begin
                if (i_plan.sel[k] && (i_plan.rank[k] == RANK_W'(r))) begin
                    o_kmer[2*r +: 2] = o_kmer[2*r +: 2] | i_window[2*k +: 2];
                end
            end
        end
    end

endmodule
